// ===== hdl/planar_frame_transform_unit_macros.svh =====
// ----------------------------------------------------------------------------
// planar frame transform unit assertion macros
// clocked assertion helpers shared by the files of the block
// ----------------------------------------------------------------------------
`ifndef PLANAR_FRAME_TRANSFORM_UNIT_MACROS_SVH
`define PLANAR_FRAME_TRANSFORM_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// check outside of reset
`define PFTU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// check that also holds while reset is applied
`define PFTU_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PFTU_ASSERT(label, prop, msg)
`define PFTU_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== hdl/pft_pkg.sv =====
// ----------------------------------------------------------------------------
// pft_pkg
// widths, cordic tables and word types of the planar frame transform unit
// ----------------------------------------------------------------------------
package pft_pkg;

    // field widths
    localparam int POS_W  = 32;
    localparam int QUAT_W = 16;
    localparam int ANG_W  = 32;

    // cordic depth
    localparam int CORDIC_STAGES_DFLT = 16;
    localparam int ATAN_ENTRIES       = 32;

    // internal datapath widths
    localparam int DIFF_W  = POS_W + 1;
    localparam int HEAD_W  = 36;
    localparam int VEC_W   = 40;
    localparam int ROT_W   = 40;
    localparam int ZRES_W  = 34;
    localparam int Q28_SH  = 28;

    // cordic gain correction, 0.607252935 in q0.28
    localparam int GAIN_W = 28;
    localparam logic [GAIN_W-1:0] GAIN_Q28 = 28'd163008219;

    // arctangent of 2^-i as binary angle, one turn is 2^32
    localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // op codes
    localparam logic OP_TO_ABS = 1'b0;
    localparam logic OP_TO_REL = 1'b1;

    // side data that travels with a word through the cordic stages
    typedef struct packed {
        logic                     op;
        logic signed [DIFF_W-1:0] rx;
        logic signed [DIFF_W-1:0] ry;
        logic signed [POS_W-1:0]  ox;
        logic signed [POS_W-1:0]  oy;
        logic signed [POS_W-1:0]  oz;
    } t_pay;

    // result word
    typedef struct packed {
        logic signed [POS_W-1:0] res_x;
        logic signed [POS_W-1:0] res_y;
        logic signed [POS_W-1:0] res_z;
        logic                    saturated;
    } t_res;

endpackage

// ===== hdl/pft_ifs.sv =====
// ----------------------------------------------------------------------------
// pft channel interfaces
// valid/ready channels for the point words and the result words
// ----------------------------------------------------------------------------
interface pft_in_if;
    import pft_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [POS_W-1:0]  point_x;
    logic signed [POS_W-1:0]  point_y;
    logic signed [POS_W-1:0]  origin_x;
    logic signed [POS_W-1:0]  origin_y;
    logic signed [POS_W-1:0]  origin_z;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;

    modport source (
        output valid, op, point_x, point_y, origin_x, origin_y, origin_z,
        output quat_x, quat_y, quat_z, quat_w,
        input  ready
    );
    modport sink (
        input  valid, op, point_x, point_y, origin_x, origin_y, origin_z,
        input  quat_x, quat_y, quat_z, quat_w,
        output ready
    );
endinterface

interface pft_out_if;
    import pft_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] res_x;
    logic signed [POS_W-1:0] res_y;
    logic signed [POS_W-1:0] res_z;
    logic                    saturated;

    modport source (
        output valid, res_x, res_y, res_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, res_x, res_y, res_z, saturated,
        output ready
    );
endinterface

// ===== hdl/planar_frame_transform_unit.sv =====
// ----------------------------------------------------------------------------
// planar_frame_transform_unit
// throughput one word per cycle while the output queue has room, one register stage per cordic iteration
// a two-word output queue lets input words flow while a result waits
// synchronous active-low reset clears the valid bits and the output queue
// ----------------------------------------------------------------------------
`include "planar_frame_transform_unit_macros.svh"

module planar_frame_transform_unit #(
    parameter int CORDIC_STAGES = pft_pkg::CORDIC_STAGES_DFLT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pft_in_if.sink    i_in,
    pft_out_if.source o_out
);
    import pft_pkg::*;

    localparam int NST    = CORDIC_STAGES;
    localparam int GL_W   = 18;
    localparam int GH_W   = ROT_W - GL_W;
    localparam int MH_W   = GH_W + GAIN_W + 1;
    localparam int ML_W   = GL_W + GAIN_W;
    localparam int SUM_W  = MH_W + GL_W + 1;
    localparam int FIN_W  = ROT_W + 1;

    localparam logic signed [GAIN_W:0]   GAIN_S  = {1'b0, GAIN_Q28};
    localparam logic signed [HEAD_W-1:0] B_ONE   = HEAD_W'(1) <<< Q28_SH;
    localparam logic signed [SUM_W-1:0]  RND     = SUM_W'(1) <<< (Q28_SH - 1);
    localparam logic [ANG_W-1:0]         A_HALF  = {1'b1, {(ANG_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0]  SAT_HI  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  SAT_LO  = {1'b1, {(POS_W-1){1'b0}}};

    // pipeline advance and output queue handshake
    logic       en;
    logic       push;
    logic       pop;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_res       r_hd;
    t_res       r_tl;

    // stage a: quaternion products and point offset
    logic                       r_a_vld;
    logic signed [2*QUAT_W-1:0] r_a_wz;
    logic signed [2*QUAT_W-1:0] r_a_xy;
    logic signed [2*QUAT_W-1:0] r_a_yy;
    logic signed [2*QUAT_W-1:0] r_a_zz;
    t_pay                       r_a_pay;
    logic signed [DIFF_W-1:0]   px_e;
    logic signed [DIFF_W-1:0]   py_e;
    logic signed [DIFF_W-1:0]   ox_e;
    logic signed [DIFF_W-1:0]   oy_e;

    // stage b: heading vector in q8.28
    logic                     r_b_vld;
    logic signed [HEAD_W-1:0] r_b_a;
    logic signed [HEAD_W-1:0] r_b_b;
    t_pay                     r_b_pay;
    logic signed [HEAD_W-1:0] sum_a;
    logic signed [HEAD_W-1:0] sum_b;

    // vectoring stages
    logic                    r_vvld  [NST+1];
    logic                    r_vzero [NST+1];
    logic signed [VEC_W-1:0] r_vx    [NST+1];
    logic signed [VEC_W-1:0] r_vy    [NST+1];
    logic [ANG_W-1:0]        r_vang  [NST+1];
    t_pay                    r_vpay  [NST+1];
    logic                    b_neg;

    // heading select stage
    logic             r_h_vld;
    logic [ANG_W-1:0] r_h_ang;
    t_pay             r_h_pay;
    logic [ANG_W-1:0] hd;

    // rotation stages
    logic                     r_rvld [NST+1];
    logic signed [ROT_W-1:0]  r_rx   [NST+1];
    logic signed [ROT_W-1:0]  r_ry   [NST+1];
    logic signed [ZRES_W-1:0] r_rz   [NST+1];
    t_pay                     r_rpay [NST+1];
    logic                     swap;

    // gain correction stages
    logic                   r_m_vld;
    logic signed [MH_W-1:0] r_m_xh;
    logic signed [MH_W-1:0] r_m_yh;
    logic [ML_W-1:0]        r_m_xl;
    logic [ML_W-1:0]        r_m_yl;
    t_pay                   r_m_pay;
    logic signed [GH_W-1:0] xh;
    logic signed [GH_W-1:0] yh;

    logic                    r_s_vld;
    logic signed [ROT_W-1:0] r_s_x;
    logic signed [ROT_W-1:0] r_s_y;
    t_pay                    r_s_pay;
    logic signed [SUM_W-1:0] full_x;
    logic signed [SUM_W-1:0] full_y;

    // final add and clamp
    logic                    r_f_vld;
    t_res                    r_f_res;
    logic signed [FIN_W-1:0] fin_x;
    logic signed [FIN_W-1:0] fin_y;
    logic                    ovf_x;
    logic                    ovf_y;

    // whole pipeline moves unless the last stage is blocked by a full queue
    assign en   = !r_f_vld || (r_cnt != 2'd2);
    assign push = en && r_f_vld;
    assign pop  = (r_cnt != 2'd0) && o_out.ready;
    assign i_in.ready = en;

    // stage a
    assign px_e = DIFF_W'(i_in.point_x);
    assign py_e = DIFF_W'(i_in.point_y);
    assign ox_e = DIFF_W'(i_in.origin_x);
    assign oy_e = DIFF_W'(i_in.origin_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_wz     <= i_in.quat_w * i_in.quat_z;
            r_a_xy     <= i_in.quat_x * i_in.quat_y;
            r_a_yy     <= i_in.quat_y * i_in.quat_y;
            r_a_zz     <= i_in.quat_z * i_in.quat_z;
            r_a_pay.op <= i_in.op;
            r_a_pay.rx <= (i_in.op == OP_TO_REL) ? px_e - ox_e : px_e;
            r_a_pay.ry <= (i_in.op == OP_TO_REL) ? py_e - oy_e : py_e;
            r_a_pay.ox <= i_in.origin_x;
            r_a_pay.oy <= i_in.origin_y;
            r_a_pay.oz <= i_in.origin_z;
        end
    end

    // stage b: a = 2(wz+xy), b = 1 - 2(yy+zz)
    assign sum_a = (HEAD_W'(r_a_wz) + HEAD_W'(r_a_xy)) <<< 1;
    assign sum_b = B_ONE - ((HEAD_W'(r_a_yy) + HEAD_W'(r_a_zz)) <<< 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_a   <= sum_a;
            r_b_b   <= sum_b;
            r_b_pay <= r_a_pay;
        end
    end

    // vectoring entry: fold the left half plane onto the right one
    assign b_neg = r_b_b[HEAD_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvld[0] <= 1'b0;
        end else if (en) begin
            r_vvld[0] <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vzero[0] <= (r_b_a == '0) && (r_b_b == '0);
            r_vx[0]    <= b_neg ? -VEC_W'(r_b_b) : VEC_W'(r_b_b);
            r_vy[0]    <= b_neg ? -VEC_W'(r_b_a) : VEC_W'(r_b_a);
            r_vang[0]  <= b_neg ? A_HALF : '0;
            r_vpay[0]  <= r_b_pay;
        end
    end

    // one vectoring iteration per stage, drives y toward zero
    for (genvar k = 0; k < NST; k++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vvld[k+1] <= 1'b0;
            end else if (en) begin
                r_vvld[k+1] <= r_vvld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_vy[k][VEC_W-1]) begin
                    r_vx[k+1]   <= r_vx[k] + (r_vy[k] >>> k);
                    r_vy[k+1]   <= r_vy[k] - (r_vx[k] >>> k);
                    r_vang[k+1] <= r_vang[k] + ATAN_TURNS[k];
                end else begin
                    r_vx[k+1]   <= r_vx[k] - (r_vy[k] >>> k);
                    r_vy[k+1]   <= r_vy[k] + (r_vx[k] >>> k);
                    r_vang[k+1] <= r_vang[k] - ATAN_TURNS[k];
                end
                r_vzero[k+1] <= r_vzero[k];
                r_vpay[k+1]  <= r_vpay[k];
            end
        end
    end

    // heading select: zero vector gives zero heading, relative mode negates
    assign hd = r_vzero[NST] ? '0 : r_vang[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (en) begin
            r_h_vld <= r_vvld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_ang <= (r_vpay[NST].op == OP_TO_REL) ? -hd : hd;
            r_h_pay <= r_vpay[NST];
        end
    end

    // rotation entry: angles beyond a quarter turn rotate the negated point
    assign swap = r_h_ang[ANG_W-1] ^ r_h_ang[ANG_W-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld[0] <= 1'b0;
        end else if (en) begin
            r_rvld[0] <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx[0]   <= swap ? -ROT_W'(r_h_pay.rx) : ROT_W'(r_h_pay.rx);
            r_ry[0]   <= swap ? -ROT_W'(r_h_pay.ry) : ROT_W'(r_h_pay.ry);
            r_rz[0]   <= ZRES_W'($signed({r_h_ang[ANG_W-1] ^ swap,
                                          r_h_ang[ANG_W-2:0]}));
            r_rpay[0] <= r_h_pay;
        end
    end

    // one rotation iteration per stage, drives the residual angle toward zero
    for (genvar k = 0; k < NST; k++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rvld[k+1] <= 1'b0;
            end else if (en) begin
                r_rvld[k+1] <= r_rvld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_rz[k][ZRES_W-1]) begin
                    r_rx[k+1] <= r_rx[k] - (r_ry[k] >>> k);
                    r_ry[k+1] <= r_ry[k] + (r_rx[k] >>> k);
                    r_rz[k+1] <= r_rz[k] - $signed(ZRES_W'(ATAN_TURNS[k]));
                end else begin
                    r_rx[k+1] <= r_rx[k] + (r_ry[k] >>> k);
                    r_ry[k+1] <= r_ry[k] - (r_rx[k] >>> k);
                    r_rz[k+1] <= r_rz[k] + $signed(ZRES_W'(ATAN_TURNS[k]));
                end
                r_rpay[k+1] <= r_rpay[k];
            end
        end
    end

    // gain multiply split into high signed and low unsigned partial products
    assign xh = $signed(r_rx[NST][ROT_W-1:GL_W]);
    assign yh = $signed(r_ry[NST][ROT_W-1:GL_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= r_rvld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_xh  <= xh * GAIN_S;
            r_m_yh  <= yh * GAIN_S;
            r_m_xl  <= r_rx[NST][GL_W-1:0] * GAIN_Q28;
            r_m_yl  <= r_ry[NST][GL_W-1:0] * GAIN_Q28;
            r_m_pay <= r_rpay[NST];
        end
    end

    // partial products summed, rounded half up and scaled back by 2^-28
    assign full_x = (SUM_W'(r_m_xh) <<< GL_W) + $signed(SUM_W'(r_m_xl)) + RND;
    assign full_y = (SUM_W'(r_m_yh) <<< GL_W) + $signed(SUM_W'(r_m_yl)) + RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (en) begin
            r_s_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_x   <= full_x[Q28_SH +: ROT_W];
            r_s_y   <= full_y[Q28_SH +: ROT_W];
            r_s_pay <= r_m_pay;
        end
    end

    // absolute mode adds the origin, then both results clamp to 32 bits
    assign fin_x = (r_s_pay.op == OP_TO_ABS) ?
                   FIN_W'(r_s_x) + FIN_W'(r_s_pay.ox) : FIN_W'(r_s_x);
    assign fin_y = (r_s_pay.op == OP_TO_ABS) ?
                   FIN_W'(r_s_y) + FIN_W'(r_s_pay.oy) : FIN_W'(r_s_y);
    assign ovf_x = (fin_x[FIN_W-1:POS_W-1] != '0) && (fin_x[FIN_W-1:POS_W-1] != '1);
    assign ovf_y = (fin_y[FIN_W-1:POS_W-1] != '0) && (fin_y[FIN_W-1:POS_W-1] != '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_res.res_x     <= ovf_x ? (fin_x[FIN_W-1] ? SAT_LO : SAT_HI)
                                       : fin_x[POS_W-1:0];
            r_f_res.res_y     <= ovf_y ? (fin_y[FIN_W-1] ? SAT_LO : SAT_HI)
                                       : fin_y[POS_W-1:0];
            r_f_res.res_z     <= r_s_pay.oz;
            r_f_res.saturated <= ovf_x || ovf_y;
        end
    end

    // two-word output queue, head drives the port
    always_comb begin
        n_cnt = r_cnt;
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop))) begin
            r_hd <= r_f_res;
        end else if (pop && (r_cnt == 2'd2)) begin
            r_hd <= r_tl;
        end
        if (push && (((r_cnt == 2'd1) && !pop) || ((r_cnt == 2'd2) && pop))) begin
            r_tl <= r_f_res;
        end
    end

    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.res_x     = r_hd.res_x;
    assign o_out.res_y     = r_hd.res_y;
    assign o_out.res_z     = r_hd.res_z;
    assign o_out.saturated = r_hd.saturated;

    // checks
    `PFTU_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out.valid, "queue not empty after reset")
    `PFTU_ASSERT(a_cnt_push, (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1), "push lost")
    `PFTU_ASSERT(a_head_hold, (r_cnt == 2'd2 && !pop) |=> $stable(r_hd), "waiting word changed")
    `PFTU_ASSERT(a_sat_edge, (o_out.valid && o_out.saturated) |-> (o_out.res_x == SAT_HI || o_out.res_x == SAT_LO || o_out.res_y == SAT_HI || o_out.res_y == SAT_LO), "saturated word not at a limit")

endmodule

// ===== verif/planar_frame_transform_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// planar_frame_transform_unit_test
// drives point and pose words into the frame transform unit, computes the
// expected heading, rotation, offset and clamping of each word on its own
// and compares every result word in order, under several idle and stall mixes
// ----------------------------------------------------------------------------
module planar_frame_transform_unit_test;
    import pft_pkg::*;

    localparam int          CLK_PERIOD  = 8;
    localparam int          N_STAGES    = CORDIC_STAGES_DFLT;
    localparam int          LATENCY     = 2 * N_STAGES + 9;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_LEN    = 150;
    localparam int          PHASE_WORDS = 200;
    localparam int          IDLE_PCT [4] = '{0, 52, 0, 32};
    localparam int          STALL_PCT[4] = '{0, 0, 52, 32};
    localparam int          P_MAX       = 32'h7fff_ffff;
    localparam int          P_MIN       = 32'h8000_0000;
    localparam int          Q_ONE       = 16384;
    localparam int          Q_HALF      = 8192;
    localparam int          Q_DIAG      = 11585;
    localparam int unsigned HALF_TURN    = 32'h8000_0000;
    localparam int unsigned QUARTER_TURN = 32'h4000_0000;
    localparam longint      GAIN_CORR   = 64'sd163008219;
    localparam longint      ROUND_HALF  = 64'sd134217728;
    localparam longint      POS_HI      = 64'sd2147483647;
    localparam longint      POS_LO      = -64'sd2147483648;

    // arctangent of 2^-i, one turn is 2^32
    localparam int unsigned ATAN_BAM [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic                     op;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  ox;
        logic signed [POS_W-1:0]  oy;
        logic signed [POS_W-1:0]  oz;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
        logic signed [QUAT_W-1:0] qw;
    } t_word;

    typedef struct {
        t_word w;
        bit    typed;
        t_res  res;
    } t_row;

    localparam t_res NO_RES = '0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic hold_req = 1'b0;

    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   hold_left = 0;
    int   n_cycles  = 0;
    int   n_sent    = 0;
    int   n_to_rel  = 0;
    int   n_sat     = 0;
    int   n_checked = 0;
    int   n_errors  = 0;

    t_res predicted_pts[$];
    t_res want;
    t_row dir_tab[$];

    pft_in_if  in_if ();
    pft_out_if out_if ();

    planar_frame_transform_unit #(
        .CORDIC_STAGES(N_STAGES)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // clamp one coordinate to signed 32 bits
    function automatic logic signed [POS_W-1:0] clamp_pos(longint v, inout bit sat);
        if (v > POS_HI) begin
            sat = 1'b1;
            return P_MAX;
        end else if (v < POS_LO) begin
            sat = 1'b1;
            return P_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    // heading from the quaternion, then rotation, offset and clamping
    function automatic t_res transform_point(t_word w);
        longint      qx, qy, qz, qw, a, b, vx, vy, tx, rz;
        int unsigned hd, ang;
        int          i;
        bit          sat;
        t_res        r;
        qx = w.qx;
        qy = w.qy;
        qz = w.qz;
        qw = w.qw;
        a  = 2 * (qw * qz + qx * qy);
        b  = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        hd = 0;
        // vectoring, left half plane folded over first
        if (a != 0 || b != 0) begin
            vx = b;
            vy = a;
            if (vx < 0) begin
                vx = -vx;
                vy = -vy;
                hd = HALF_TURN;
            end
            for (i = 0; i < N_STAGES; i++) begin
                if (vy >= 0) begin
                    tx = vx + (vy >>> i);
                    vy = vy - (vx >>> i);
                    hd += ATAN_BAM[i];
                end else begin
                    tx = vx - (vy >>> i);
                    vy = vy + (vx >>> i);
                    hd -= ATAN_BAM[i];
                end
                vx = tx;
            end
        end
        // vector and angle of the rotation
        if (w.op == OP_TO_ABS) begin
            vx  = longint'(w.px);
            vy  = longint'(w.py);
            ang = hd;
        end else begin
            vx  = longint'(w.px) - longint'(w.ox);
            vy  = longint'(w.py) - longint'(w.oy);
            ang = 32'd0 - hd;
        end
        if (((ang + QUARTER_TURN) & HALF_TURN) != 0) begin
            vx  = -vx;
            vy  = -vy;
            ang += HALF_TURN;
        end
        rz = longint'(int'(ang));
        for (i = 0; i < N_STAGES; i++) begin
            if (rz >= 0) begin
                tx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                rz -= longint'(ATAN_BAM[i]);
            end else begin
                tx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                rz += longint'(ATAN_BAM[i]);
            end
            vx = tx;
        end
        // gain correction, rounded half up
        vx = (vx * GAIN_CORR + ROUND_HALF) >>> 28;
        vy = (vy * GAIN_CORR + ROUND_HALF) >>> 28;
        if (w.op == OP_TO_ABS) begin
            vx += longint'(w.ox);
            vy += longint'(w.oy);
        end
        sat         = 1'b0;
        r.res_x     = clamp_pos(vx, sat);
        r.res_y     = clamp_pos(vy, sat);
        r.res_z     = w.oz;
        r.saturated = sat;
        return r;
    endfunction

    function automatic t_word mk(logic op, int px, int py, int ox, int oy, int oz,
                                 int qx, int qy, int qz, int qw);
        t_word w;
        w.op = op;
        w.px = px;
        w.py = py;
        w.ox = ox;
        w.oy = oy;
        w.oz = oz;
        w.qx = 16'(qx);
        w.qy = 16'(qy);
        w.qz = 16'(qz);
        w.qw = 16'(qw);
        return w;
    endfunction

    // mostly moderate coordinates, some full range and edge values
    function automatic int pick_pos();
        int r;
        r = $urandom_range(9);
        if (r < 5)
            return int'($urandom_range(1 << 25)) - (1 << 24);
        else if (r < 7)
            return $urandom;
        else if (r == 7)
            return int'($urandom) >>> $urandom_range(1, 16);
        case ($urandom_range(3))
            0: return P_MAX;
            1: return P_MIN;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int pick_quat();
        return int'($urandom_range(2 * Q_ONE)) - Q_ONE;
    endfunction

    // mostly pure yaw orientations, then noisy, arbitrary and degenerate ones
    function automatic t_word random_word();
        t_word w;
        real   th;
        int    r, s, v;
        w = mk($urandom_range(1), pick_pos(), pick_pos(), pick_pos(), pick_pos(),
               $urandom, 0, 0, 0, 0);
        r = $urandom_range(9);
        if (r < 8) begin
            th   = $urandom_range(65535) * 6.283185307179586 / 65536.0;
            w.qz = 16'($rtoi($sin(th / 2.0) * 16384.0));
            w.qw = 16'($rtoi($cos(th / 2.0) * 16384.0));
            if (r >= 6) begin
                w.qx = 16'(int'($urandom_range(512)) - 256);
                w.qy = 16'(int'($urandom_range(512)) - 256);
            end
        end else if (r == 8) begin
            w.qx = 16'(pick_quat());
            w.qy = 16'(pick_quat());
            w.qz = 16'(pick_quat());
            w.qw = 16'(pick_quat());
        end else if ($urandom_range(1) == 0) begin
            // both heading arguments zero
            s    = $urandom_range(1) ? 1 : -1;
            v    = pick_quat();
            w.qx = 16'(v);
            w.qy = 16'(s * Q_HALF);
            w.qz = 16'(Q_HALF);
            w.qw = 16'(-v * s);
        end else begin
            w.qx = 16'($urandom_range(1) ? Q_ONE : -Q_ONE);
            w.qy = 16'($urandom_range(1) ? Q_ONE : -Q_ONE);
            w.qz = 16'($urandom_range(1) ? Q_ONE : -Q_ONE);
            w.qw = 16'($urandom_range(1) ? Q_ONE : -Q_ONE);
        end
        return w;
    endfunction

    // offer one word, random idle cycles first, and log its expected result
    task automatic send_word(input t_word w, input bit typed, input t_res res);
        t_res r;
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.op       <= w.op;
        in_if.point_x  <= w.px;
        in_if.point_y  <= w.py;
        in_if.origin_x <= w.ox;
        in_if.origin_y <= w.oy;
        in_if.origin_z <= w.oz;
        in_if.quat_x   <= w.qx;
        in_if.quat_y   <= w.qy;
        in_if.quat_z   <= w.qz;
        in_if.quat_w   <= w.qw;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        r = typed ? res : transform_point(w);
        predicted_pts.push_back(r);
        n_sent++;
        if (w.op == OP_TO_REL) n_to_rel++;
        if (r.saturated) n_sat++;
    endtask

    // stop offering words until every expected result is back
    task automatic wait_results();
        in_if.valid <= 1'b0;
        while (predicted_pts.size() != 0) @(posedge clk);
    endtask

    // result side: random stalls, long hold-off on request, in-order check
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (predicted_pts.size() == 0) begin
                    $display("%0t: unexpected result word x=%0d y=%0d z=%0d sat=%0b",
                             $time, out_if.res_x, out_if.res_y, out_if.res_z,
                             out_if.saturated);
                    n_errors++;
                end else begin
                    want = predicted_pts.pop_front();
                    if (out_if.res_x !== want.res_x) begin
                        $display("%0t: res_x expected %0d, got %0d",
                                 $time, want.res_x, out_if.res_x);
                        n_errors++;
                    end
                    if (out_if.res_y !== want.res_y) begin
                        $display("%0t: res_y expected %0d, got %0d",
                                 $time, want.res_y, out_if.res_y);
                        n_errors++;
                    end
                    if (out_if.res_z !== want.res_z) begin
                        $display("%0t: res_z expected %0d, got %0d",
                                 $time, want.res_z, out_if.res_z);
                        n_errors++;
                    end
                    if (out_if.saturated !== want.saturated) begin
                        $display("%0t: saturated expected %0b, got %0b",
                                 $time, want.saturated, out_if.saturated);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_left = HOLD_LEN;
                hold_req     <= 1'b0;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, n_cycles, predicted_pts.size());
            $display("** planar_frame_transform_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int k;
        int ph;
        in_if.valid    = 1'b0;
        in_if.op       = OP_TO_ABS;
        in_if.point_x  = '0;
        in_if.point_y  = '0;
        in_if.origin_x = '0;
        in_if.origin_y = '0;
        in_if.origin_z = '0;
        in_if.quat_x   = '0;
        in_if.quat_y   = '0;
        in_if.quat_z   = '0;
        in_if.quat_w   = '0;
        out_if.ready   = 1'b0;

        // zero-heading and identity orientations give exact results, at zero and at the rails
        dir_tab.push_back('{mk(OP_TO_ABS, 0, 0, 0, 0, 0, 0, Q_HALF, Q_HALF, 0), 1'b1,
                            t_res'{32'sd0, 32'sd0, 32'sd0, 1'b0}});
        dir_tab.push_back('{mk(OP_TO_REL, 0, 0, 0, 0, 0, 0, Q_HALF, Q_HALF, 0), 1'b1,
                            t_res'{32'sd0, 32'sd0, 32'sd0, 1'b0}});
        dir_tab.push_back('{mk(OP_TO_ABS, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, 0, 0, 0, Q_ONE),
                            1'b1, t_res'{P_MAX, P_MAX, P_MAX, 1'b1}});
        dir_tab.push_back('{mk(OP_TO_ABS, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN,
                               0, Q_HALF, Q_HALF, 0),
                            1'b1, t_res'{P_MIN, P_MIN, P_MIN, 1'b1}});
        dir_tab.push_back('{mk(OP_TO_REL, P_MAX, P_MAX, P_MIN, P_MIN, -1, 0, 0, 0, Q_ONE),
                            1'b1, t_res'{P_MAX, P_MAX, -32'sd1, 1'b1}});
        dir_tab.push_back('{mk(OP_TO_REL, P_MIN, P_MIN, P_MAX, P_MAX, 0,
                               0, Q_HALF, Q_HALF, 0),
                            1'b1, t_res'{P_MIN, P_MIN, 32'sd0, 1'b1}});
        // headings around the circle, including beyond a quarter turn
        dir_tab.push_back('{mk(OP_TO_ABS, 65536, 0, 0, 0, 7, 0, 0, 0, Q_ONE), 1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_ABS, 65536, 0, 0, 0, 7, 0, 0, Q_ONE, 0), 1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_ABS, 65536, 131072, 1000, -1000, 3,
                               0, 0, Q_DIAG, Q_DIAG), 1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_REL, 65536, 131072, 1000, -1000, 3,
                               0, 0, -Q_DIAG, Q_DIAG), 1'b0, NO_RES});
        // non-unit orientations and quaternion extremes
        dir_tab.push_back('{mk(OP_TO_REL, 300000, -70000, -5, 9, 11, 0, 0, Q_ONE, -Q_ONE),
                            1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_REL, -300000, 70000, 5, -9, -11,
                               -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE), 1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_ABS, 12345678, -8765432, 0, 0, 0,
                               Q_ONE, Q_ONE, Q_ONE, Q_ONE), 1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_ABS, 12345678, -8765432, 1, 2, 3, Q_ONE, 0, 0, 0),
                            1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_ABS, 12345678, -8765432, 1, 2, 3, 0, Q_ONE, 0, 0),
                            1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_ABS, 65536, 65536, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_RES});
        // position extremes with a real rotation
        dir_tab.push_back('{mk(OP_TO_REL, P_MAX, P_MIN, P_MIN, P_MAX, P_MIN,
                               0, 0, Q_DIAG, Q_DIAG), 1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_ABS, -1, -1, -1, -1, 1, 0, 0, -Q_DIAG, Q_DIAG),
                            1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_REL, 32'h1234_5678, -32'h0edc_ba98, -77777, 88888,
                               P_MAX, 0, 0, 0, -Q_ONE), 1'b0, NO_RES});
        // zero heading vector from a mixed quaternion
        dir_tab.push_back('{mk(OP_TO_ABS, 777777, -555555, 4444, 3333, 2,
                               -Q_HALF, Q_HALF, Q_HALF, Q_HALF), 1'b0, NO_RES});
        dir_tab.push_back('{mk(OP_TO_REL, 777777, -555555, 4444, 3333, 2,
                               -Q_HALF, Q_HALF, Q_HALF, Q_HALF), 1'b0, NO_RES});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, no idling
        for (k = 0; k < dir_tab.size(); k++)
            send_word(dir_tab[k].w, dir_tab[k].typed, dir_tab[k].res);
        wait_results();

        // random words under each idle and stall mix
        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = IDLE_PCT[ph];
            stall_pct = STALL_PCT[ph];
            repeat (PHASE_WORDS) send_word(random_word(), 1'b0, NO_RES);
            wait_results();
        end

        // long receiver hold-off while words keep coming
        idle_pct  = 0;
        stall_pct = 0;
        hold_req <= 1'b1;
        repeat (80) send_word(random_word(), 1'b0, NO_RES);
        wait_results();

        repeat (2 * LATENCY) @(posedge clk);
        $display("%0d words sent (%0d to relative, %0d saturating), %0d results checked",
                 n_sent, n_to_rel, n_sat, n_checked);
        $display("directed rails and headings, four idle/stall mixes, one long hold-off");
        if (n_errors == 0 && predicted_pts.size() == 0) begin
            $display("** planar_frame_transform_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never seen", n_errors,
                     predicted_pts.size());
            $display("** planar_frame_transform_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pft_pkg.sv
hdl/pft_ifs.sv
hdl/planar_frame_transform_unit.sv
verif/planar_frame_transform_unit_test.sv
